[hdl/smad_pkg.sv]
// ----------------------------------------------------------------------------
// Sliding median absolute deviation package
// Fixed widths, register map and the control bundles passed between the
// cell row, the summing tree and the top level.
// ----------------------------------------------------------------------------
package smad_pkg;

    // Fixed widths of the result word and of the configuration port.
    localparam int COST_W   = 38;
    localparam int MEDIAN_W = 32;
    localparam int WSIZE_W  = 7;
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 3;

    // Register map, indexed by word address.
    localparam logic REG_WINDOW_SIZE = 1'b0;

    // Window size after reset.
    localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd3;

    // Per-cycle command broadcast to every cell of the row.
    typedef struct packed {
        logic evict;   // drop the oldest sample and close the gap
        logic insert;  // open a slot and place the new sample
    } smad_cell_ctl_t;

    // Control of the summing tree.
    typedef struct packed {
        logic advance; // every stage moves on by one
        logic tag;     // the word entering the leaves gives a result
    } smad_tree_ctl_t;

endpackage

[hdl/smad_cell.sv]
// ----------------------------------------------------------------------------
// Sorted window cell
// Holds one sample and its age. Closes up on eviction, opens up on insertion
// and gives its absolute deviation from the median.
// ----------------------------------------------------------------------------
module smad_cell
    import smad_pkg::*;
#(
    parameter int SAMPLE_BITS = 32,
    parameter int AGE_W       = 6,
    parameter int CNT_W       = 7,
    parameter int INDEX       = 0
)
(
    input  logic                   clk,
    input  smad_cell_ctl_t         ctl,
    input  logic [CNT_W-1:0]       fill,
    input  logic [AGE_W-1:0]       last_age,
    input  logic [CNT_W-1:0]       med_idx,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [SAMPLE_BITS-1:0] key_value,
    input  logic [AGE_W-1:0]       key_age,
    input  logic [SAMPLE_BITS-1:0] median,
    input  logic [SAMPLE_BITS-1:0] up_value,
    input  logic [AGE_W-1:0]       up_age,
    input  logic [SAMPLE_BITS-1:0] dn_value,
    input  logic [AGE_W-1:0]       dn_age,
    input  logic                   dn_greater,
    output logic [SAMPLE_BITS-1:0] value,
    output logic [AGE_W-1:0]       age,
    output logic                   greater,
    output logic                   oldest,
    output logic [SAMPLE_BITS-1:0] sel_value,
    output logic [SAMPLE_BITS-1:0] dev
);

    logic [SAMPLE_BITS-1:0] value_reg;
    logic [SAMPLE_BITS-1:0] value_next;
    logic [AGE_W-1:0]       age_reg;
    logic [AGE_W-1:0]       age_next;
    logic                   live;
    logic                   key_below;

    // The cell holds a sample when its place lies below the fill count.
    assign live = CNT_W'(INDEX) < fill;

    // The oldest sample is the one whose age reached the window length less one.
    assign oldest = live && (age_reg == last_age);

    // Order is by value, then older first, so the evicted key splits the row.
    assign key_below = (key_value < value_reg) ||
                       ((key_value == value_reg) && (key_age > age_reg));

    // The new sample goes in front of the first larger or empty cell.
    assign greater = !live || (value_reg > sample);

    // Next contents: close the gap, or open one and shift up.
    always_comb
    begin
        value_next = value_reg;
        age_next   = age_reg;
        if (ctl.evict)
        begin
            if (oldest || key_below)
            begin
                value_next = up_value;
                age_next   = up_age;
            end
        end
        else if (ctl.insert)
        begin
            if (dn_greater)
            begin
                value_next = dn_value;
                age_next   = dn_age + 1'b1;
            end
            else if (greater)
            begin
                value_next = sample;
                age_next   = '0;
            end
            else
            begin
                age_next = age_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

    // Median pick and absolute deviation from the broadcast median.
    assign sel_value = (CNT_W'(INDEX) == med_idx) ? value_reg : '0;

    always_comb
    begin
        if (!live)
        begin
            dev = '0;
        end
        else if (value_reg >= median)
        begin
            dev = value_reg - median;
        end
        else
        begin
            dev = median - value_reg;
        end
    end

    assign value = value_reg;
    assign age   = age_reg;

endmodule

[hdl/smad_sum_tree.sv]
// ----------------------------------------------------------------------------
// Deviation summing tree
// Registered binary adder tree, one level per cycle while advance is set,
// carrying the median and a result tag alongside the partial sums.
// ----------------------------------------------------------------------------
module smad_sum_tree
    import smad_pkg::*;
#(
    parameter int LEVELS      = 6,
    parameter int SAMPLE_BITS = 32,
    parameter int SUM_W       = 39
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  smad_tree_ctl_t                       ctl,
    input  logic [(1<<LEVELS)-1:0][SAMPLE_BITS-1:0] leaf,
    input  logic [SAMPLE_BITS-1:0]               median_in,
    output logic [SUM_W-1:0]                     sum,
    output logic [SAMPLE_BITS-1:0]               median_out,
    output logic                                 valid
);

    localparam int LEAVES = 1 << LEVELS;

    logic [SUM_W-1:0]       node_reg   [1:2*LEAVES-1];
    logic [SAMPLE_BITS-1:0] median_reg [0:LEVELS];
    logic                   valid_reg  [0:LEVELS];

    // Heap-ordered nodes: leaves load, every inner node adds its two children.
    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            for (int i = 0; i < LEAVES; i++)
            begin
                node_reg[LEAVES+i] <= SUM_W'(leaf[i]);
            end
            for (int i = 1; i < LEAVES; i++)
            begin
                node_reg[i] <= node_reg[2*i] + node_reg[2*i+1];
            end
            median_reg[0] <= median_in;
            for (int k = 1; k <= LEVELS; k++)
            begin
                median_reg[k] <= median_reg[k-1];
            end
        end
    end

    // Result tags travel level by level with the sums.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LEVELS; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (ctl.advance)
        begin
            valid_reg[0] <= ctl.tag;
            for (int k = 1; k <= LEVELS; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    assign sum        = node_reg[1];
    assign median_out = median_reg[LEVELS];
    assign valid      = valid_reg[LEVELS];

endmodule

[hdl/sliding_median_abs_deviation.sv]
// ----------------------------------------------------------------------------
// Sliding median absolute deviation
// Keeps the latest window_size samples in a sorted row of cells and gives the
// median and the sum of absolute deviations from it for every full window.
// ----------------------------------------------------------------------------
// Pacing: the block takes no new word while the insert pass of the last one is
//   pending, since the evict and insert passes of the cell row may not overlap.
// Result path: evict pass, insert pass, the leaf registers and adder levels of
//   the tree, then the output register behind result_valid.
// Reset: window_size returns to 3 and the window is empty; the cell contents
//   are not cleared, the fill count alone marks them.
// ----------------------------------------------------------------------------
module sliding_median_abs_deviation
    import smad_pkg::*;
#(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready,
    // sample input
    input  logic                   sample_valid,
    output logic                   sample_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    // result output
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic [COST_W-1:0]      cost,
    output logic [MEDIAN_W-1:0]    median
);

    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int AGE_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LEVELS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 0;
    localparam int LEAVES = 1 << LEVELS;
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;

    logic [WSIZE_W-1:0]     window_size_reg;
    logic [CNT_W-1:0]       fill_reg;
    logic [CNT_W-1:0]       fill_next;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   insert_pend_reg;
    logic                   meas_pend_reg;
    logic                   meas_res_reg;
    logic                   out_valid_reg;
    logic [COST_W-1:0]      cost_reg;
    logic [MEDIAN_W-1:0]    median_reg;

    logic                   cfg_write;
    logic [CNT_W-1:0]       w_eff;
    logic [CNT_W-1:0]       med_idx;
    logic [AGE_W-1:0]       last_age;
    logic                   full;
    logic                   accept;
    logic                   advance;
    smad_cell_ctl_t         cell_ctl;
    smad_tree_ctl_t         tree_ctl;

    logic [SAMPLE_BITS-1:0] cell_value   [WINDOW_MAX];
    logic [AGE_W-1:0]       cell_age     [WINDOW_MAX];
    logic                   cell_greater [WINDOW_MAX];
    logic                   cell_oldest  [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] cell_sel     [WINDOW_MAX];
    logic [LEAVES-1:0][SAMPLE_BITS-1:0] leaf;

    logic [SAMPLE_BITS-1:0] key_value;
    logic [AGE_W-1:0]       key_age;
    logic [SAMPLE_BITS-1:0] med_value;
    logic [SUM_W-1:0]       tree_sum;
    logic [SAMPLE_BITS-1:0] tree_median;
    logic                   tree_valid;

    // Configuration port: zero wait, a write lands on the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE);
    assign prdata    = (paddr[2] == REG_WINDOW_SIZE) ? PDATA_W'(window_size_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WSIZE_RESET;
        end
        else if (cfg_write)
        begin
            window_size_reg <= pwdata[WSIZE_W-1:0];
        end
    end

    // Effective window: zero acts as one, large sizes clamp to the cell count.
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            w_eff = CNT_W'(1);
        end
        else if (int'(window_size_reg) > WINDOW_MAX)
        begin
            w_eff = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            w_eff = CNT_W'(window_size_reg);
        end
    end

    assign med_idx  = w_eff >> 1;
    assign last_age = AGE_W'(w_eff - 1'b1);
    assign full     = (fill_reg == w_eff);

    // The whole pipeline holds while a finished sum waits on a full output.
    assign advance      = !(tree_valid && out_valid_reg && !result_ready);
    assign sample_ready = advance && !insert_pend_reg;
    assign accept       = sample_valid && sample_ready;

    // Evict on the accepting edge, insert on a later edge with advance set.
    assign cell_ctl.evict  = accept && full;
    assign cell_ctl.insert = insert_pend_reg && advance;

    // Fill count follows the evict and insert passes; a write empties the window.
    always_comb
    begin
        fill_next = fill_reg;
        if (cfg_write)
        begin
            fill_next = '0;
        end
        else if (accept)
        begin
            fill_next = fill_reg - CNT_W'(full);
        end
        else if (cell_ctl.insert)
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    // Sequencing of one word through evict, insert and measure.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg        <= '0;
            insert_pend_reg <= 1'b0;
            meas_pend_reg   <= 1'b0;
            meas_res_reg    <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (accept)
            begin
                insert_pend_reg <= 1'b1;
            end
            else if (cell_ctl.insert)
            begin
                insert_pend_reg <= 1'b0;
            end
            if (cell_ctl.insert)
            begin
                meas_pend_reg <= 1'b1;
                meas_res_reg  <= ((fill_reg + 1'b1) == w_eff);
            end
            else if (advance)
            begin
                meas_pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
        end
    end

    // Row of cells, each linked to the neighbour above and below.
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        logic [SAMPLE_BITS-1:0] up_value;
        logic [AGE_W-1:0]       up_age;
        logic [SAMPLE_BITS-1:0] dn_value;
        logic [AGE_W-1:0]       dn_age;
        logic                   dn_greater;

        if (i + 1 < WINDOW_MAX)
        begin : g_up
            assign up_value = cell_value[i+1];
            assign up_age   = cell_age[i+1];
        end
        else
        begin : g_top
            assign up_value = '0;
            assign up_age   = '0;
        end

        if (i > 0)
        begin : g_dn
            assign dn_value   = cell_value[i-1];
            assign dn_age     = cell_age[i-1];
            assign dn_greater = cell_greater[i-1];
        end
        else
        begin : g_bottom
            assign dn_value   = '0;
            assign dn_age     = '0;
            assign dn_greater = 1'b0;
        end

        smad_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .AGE_W       (AGE_W),
            .CNT_W       (CNT_W),
            .INDEX       (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (cell_ctl),
            .fill       (fill_reg),
            .last_age   (last_age),
            .med_idx    (med_idx),
            .sample     (sample_reg),
            .key_value  (key_value),
            .key_age    (key_age),
            .median     (med_value),
            .up_value   (up_value),
            .up_age     (up_age),
            .dn_value   (dn_value),
            .dn_age     (dn_age),
            .dn_greater (dn_greater),
            .value      (cell_value[i]),
            .age        (cell_age[i]),
            .greater    (cell_greater[i]),
            .oldest     (cell_oldest[i]),
            .sel_value  (cell_sel[i]),
            .dev        (leaf[i])
        );
    end

    for (genvar i = WINDOW_MAX; i < LEAVES; i++)
    begin : g_pad
        assign leaf[i] = '0;
    end

    // Broadcast of the evicted key and of the median, as wide OR trees.
    always_comb
    begin
        key_value = '0;
        key_age   = '0;
        med_value = '0;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            key_value = key_value | (cell_oldest[i] ? cell_value[i] : '0);
            key_age   = key_age | (cell_oldest[i] ? cell_age[i] : '0);
            med_value = med_value | cell_sel[i];
        end
    end

    // Summing tree takes the deviations on an advancing edge after the insert.
    assign tree_ctl.advance = advance;
    assign tree_ctl.tag     = meas_pend_reg && meas_res_reg;

    smad_sum_tree #(
        .LEVELS      (LEVELS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_tree (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (tree_ctl),
        .leaf       (leaf),
        .median_in  (med_value),
        .sum        (tree_sum),
        .median_out (tree_median),
        .valid      (tree_valid)
    );

    // Output register parts the tree from the consumer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (tree_valid && advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tree_valid && advance)
        begin
            cost_reg   <= COST_W'(tree_sum);
            median_reg <= MEDIAN_W'(tree_median);
        end
    end

    assign result_valid = out_valid_reg;
    assign cost         = cost_reg;
    assign median       = median_reg;

endmodule

[bench/tb_sliding_median_abs_deviation.sv]
// ----------------------------------------------------------------------------
// Testbench for the sliding median absolute deviation block
// Streams unsigned samples through the block under several window sizes,
// rebuilds each full window on the bench side, and checks every result word
// (median and sum of absolute deviations) against the bench's own figures.
// Both channels idle at random; the result side also holds off for a long
// stretch so that the block backs up into its sample input.
// ----------------------------------------------------------------------------
module tb_sliding_median_abs_deviation;
    import smad_pkg::*;

    localparam int WINDOW_MAX     = 64;
    localparam int SAMPLE_BITS    = 32;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TOTAL_SAMPLES  = 1850;

    // Word index with no register behind it; writes there must change nothing.
    localparam int unsigned REG_SPARE = 1;

    typedef enum int {SPREAD_FULL, SPREAD_NARROW, SPREAD_EDGES, SPREAD_MIXED} spread_t;
    typedef enum int {DRAIN_FREE, DRAIN_LIGHT, DRAIN_HEAVY, DRAIN_TOGGLE} drain_t;

    typedef struct packed {
        logic [COST_W-1:0]   cost;
        logic [MEDIAN_W-1:0] median;
    } mad_word_t;

    // Tracks the window contents and holds the words the block still owes.
    class mad_tracker;
        logic [WSIZE_W-1:0]     wsize_reg;
        logic [SAMPLE_BITS-1:0] by_age [$];
        mad_word_t              due_words [$];
        int                     errors;

        function new();
            wsize_reg = WSIZE_RESET;
            errors    = 0;
        endfunction

        // A size of zero acts as one; anything above the store depth saturates.
        function int span();
            int w;
            w = wsize_reg;
            if (w < 1)
                w = 1;
            if (w > WINDOW_MAX)
                w = WINDOW_MAX;
            return w;
        endfunction

        function void write_reg(int unsigned index, logic [PDATA_W-1:0] data);
            if (index == REG_WINDOW_SIZE) begin
                wsize_reg = data[WSIZE_W-1:0];
                by_age.delete();
            end
        endfunction

        // Slides the window on by one sample and, once full, works out the word.
        function void note_sample(logic [SAMPLE_BITS-1:0] s);
            int w;
            int i;
            int j;
            logic [SAMPLE_BITS-1:0] ranked [WINDOW_MAX];
            logic [SAMPLE_BITS-1:0] v;
            logic [SAMPLE_BITS-1:0] mid;
            logic [COST_W-1:0]      total;
            mad_word_t              e;
            w = span();
            while (by_age.size() >= w)
                v = by_age.pop_front();
            by_age.insert(by_age.size(), s);
            if (by_age.size() != w)
                return;
            for (i = 0; i < w; i++) begin
                v = by_age[i];
                j = i;
                while (j > 0 && ranked[j-1] > v) begin
                    ranked[j] = ranked[j-1];
                    j--;
                end
                ranked[j] = v;
            end
            mid   = ranked[w/2];
            total = '0;
            for (i = 0; i < w; i++) begin
                if (ranked[i] >= mid)
                    total = total + {{(COST_W-SAMPLE_BITS){1'b0}}, ranked[i] - mid};
                else
                    total = total + {{(COST_W-SAMPLE_BITS){1'b0}}, mid - ranked[i]};
            end
            e.cost   = total;
            e.median = mid;
            due_words.insert(due_words.size(), e);
        endfunction

        function void check_result(logic [COST_W-1:0] c, logic [MEDIAN_W-1:0] m);
            mad_word_t e;
            if (due_words.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result word with none due: cost %0d median %0d", c, m);
                return;
            end
            e = due_words.pop_front();
            if (c !== e.cost || m !== e.median) begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch: cost exp %0d got %0d, median exp %0d got %0d",
                             e.cost, c, e.median, m);
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;
    logic                   sample_valid;
    logic                   sample_ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   result_valid;
    logic                   result_ready;
    logic [COST_W-1:0]      cost;
    logic [MEDIAN_W-1:0]    median;

    mad_tracker tracker;
    logic       in_taken = 1'b0;
    bit         hold_req = 1'b0;
    int         burst_left = 0;
    int         idle_cycles = 0;
    int         size_plan [8];

    sliding_median_abs_deviation #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cost         (cost),
        .median       (median)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Handshakes are observed at the rising edge; drivers act on the falling one.
    always @(posedge clk)
    begin
        in_taken <= rst_n && sample_valid && sample_ready;
        if (rst_n && sample_valid && sample_ready)
            tracker.note_sample(sample);
        if (rst_n && result_valid && result_ready)
            tracker.check_result(cost, median);
    end

    // Watchdog on cycles with no word moving on either channel.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((sample_valid && sample_ready) || (result_valid && result_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_sliding_median_abs_deviation: done, errors");
                $finish;
            end
        end
    end

    // Result side: changes stall pattern every so often, and holds off on request.
    initial
    begin : result_sink
        drain_t mode;
        int     stretch;
        int     k;
        result_ready = 1'b0;
        mode         = DRAIN_FREE;
        stretch      = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                result_ready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            if (stretch == 0) begin
                mode    = drain_t'($urandom_range(0, 3));
                stretch = $urandom_range(20, 200);
            end
            stretch--;
            case (mode)
                DRAIN_FREE:   result_ready <= 1'b1;
                DRAIN_LIGHT:  result_ready <= ($urandom_range(0, 9) < 8);
                DRAIN_HEAVY:  result_ready <= ($urandom_range(0, 9) < 3);
                default:      result_ready <= ~result_ready;
            endcase
        end
    end

    // Offers one sample word, pacing the sender in bursts with gaps between.
    task automatic offer(input logic [SAMPLE_BITS-1:0] v);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                sample_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        sample_valid <= 1'b1;
        sample       <= v;
        do
            @(negedge clk);
        while (!in_taken);
    endtask

    // Stops sending and waits for every owed word, then for the pipeline to empty.
    task automatic settle();
        sample_valid <= 1'b0;
        @(negedge clk);
        while (tracker.due_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Setup then access cycle on the configuration port; called while idle.
    task automatic write_reg(input int unsigned index, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(index * 4);
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.write_reg(index, data);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample(spread_t spread);
        case (spread)
            SPREAD_FULL:   return $urandom;
            SPREAD_NARROW: return $urandom_range(0, 7);
            SPREAD_EDGES:  return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3)
                                  : 32'hFFFF_FFFF - $urandom_range(0, 3);
            default:       return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                  : $urandom;
        endcase
    endfunction

    initial
    begin : stimulus
        int          phase;
        int          n;
        int          i;
        int          sent;
        int          wsize;
        spread_t     spread;
        tracker      = new();
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        sample_valid = 1'b0;
        sample       = '0;
        size_plan    = '{127, 1, 64, 0, 2, 65, 3, 32};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset window of three: all zeros, all ones, a mix, then equal samples.
        offer(32'h0000_0000);
        offer(32'h0000_0000);
        offer(32'h0000_0000);
        offer(32'hFFFF_FFFF);
        offer(32'hFFFF_FFFF);
        offer(32'hFFFF_FFFF);
        offer(32'h0000_0000);
        offer(32'h0000_0005);
        offer(32'h0000_0005);
        settle();

        // A write to the spare word must leave the window as it was.
        write_reg(REG_SPARE, $urandom);
        offer(32'h0000_0005);
        offer(32'h8000_0001);
        settle();

        // Size zero behaves as a window of one.
        write_reg(REG_WINDOW_SIZE, 32'h0000_0000);
        offer(32'h8000_0000);
        offer(32'h7FFF_FFFF);
        offer(32'h0000_0001);
        settle();

        // Even size: the upper middle sample is the median.
        write_reg(REG_WINDOW_SIZE, 32'h0000_0002);
        offer(32'd10);
        offer(32'd20);
        offer(32'hFFFF_FFFF);
        offer(32'h0000_0000);
        settle();

        // Random phases over a spread of window sizes, extremes first.
        sent  = 18;
        phase = 0;
        while (sent < TOTAL_SAMPLES) begin
            if (phase < 8)
                wsize = size_plan[phase];
            else if ($urandom_range(0, 4) == 0)
                wsize = $urandom_range(0, 127);
            else
                wsize = $urandom_range(1, 12);
            write_reg(REG_WINDOW_SIZE, ($urandom & 32'hFFFF_FF80) | wsize);
            n      = tracker.span() + $urandom_range(24, 110);
            spread = spread_t'($urandom_range(0, 3));
            // With a window of one every word gives a result: good for backing up.
            if (phase == 1)
                hold_req = 1'b1;
            for (i = 0; i < n; i++) begin
                if ((phase == 2 && i == 90) || $urandom_range(0, 299) == 0) begin
                    sample_valid <= 1'b0;
                    @(negedge clk);
                    while (tracker.due_words.size() != 0)
                        @(negedge clk);
                end
                offer(pick_sample(spread));
            end
            sent = sent + n;
            settle();
            phase++;
        end

        if (tracker.errors == 0)
            $display("tb_sliding_median_abs_deviation: done, clean");
        else
            $display("tb_sliding_median_abs_deviation: done, errors");
        $finish;
    end

endmodule
